// File: hdl/pmt_pkg.sv
// ============================================================================
// PS/2 mouse position tracker package
// Shared types, field widths, protocol constants and request codes.
// ============================================================================
package pmt_pkg;

    // Virtual screen size, which sets the reset window and position.
    localparam int VIRT_W = 640;
    localparam int VIRT_H = 200;

    // Field widths.
    localparam int POS_W   = 16;
    localparam int DIVS_W  = 15;
    localparam int REM_W   = 17;
    localparam int QUOT_W  = REM_W + 1;
    localparam int BYTE_W  = 8;
    localparam int BTN_N   = 3;
    localparam int REQ_W   = 3;
    localparam int SEL_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_VAL_W = 16;

    // Reset values of the configuration registers and the position.
    localparam logic signed [POS_W-1:0] RST_MIN_X = '0;
    localparam logic signed [POS_W-1:0] RST_MAX_X = POS_W'(VIRT_W - 1);
    localparam logic signed [POS_W-1:0] RST_MIN_Y = '0;
    localparam logic signed [POS_W-1:0] RST_MAX_Y = POS_W'(VIRT_H - 1);
    localparam logic signed [POS_W-1:0] RST_CUR_X = POS_W'(VIRT_W / 2);
    localparam logic signed [POS_W-1:0] RST_CUR_Y = POS_W'(VIRT_H / 2);
    localparam logic [DIVS_W-1:0]       DEF_DIV_X = DIVS_W'(8);
    localparam logic [DIVS_W-1:0]       DEF_DIV_Y = DIVS_W'(16);

    // Bytes from the mouse that never start a packet.
    localparam logic [BYTE_W-1:0] MOUSE_ACK       = 8'hFA;
    localparam logic [BYTE_W-1:0] MOUSE_RESEND    = 8'hFE;
    localparam logic [BYTE_W-1:0] MOUSE_SELF_TEST = 8'hAA;

    // Bit positions in the packet flags byte.
    localparam int FLAG_SYNC  = 3;
    localparam int FLAG_XSIGN = 4;
    localparam int FLAG_YSIGN = 5;
    localparam int FLAG_XOVF  = 6;
    localparam int FLAG_YOVF  = 7;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_AUX_BYTE     = 3'd0,
        REQ_SET_POS      = 3'd1,
        REQ_READ_PRESS   = 3'd2,
        REQ_READ_RELEASE = 3'd3,
        REQ_READ_MOTION  = 3'd4
    } t_req;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X    = 3'd0,
        CFG_MAX_X    = 3'd1,
        CFG_MIN_Y    = 3'd2,
        CFG_MAX_Y    = 3'd3,
        CFG_DIV_X    = 3'd4,
        CFG_DIV_Y    = 3'd5,
        CFG_TRACK_EN = 3'd6
    } t_cfg_idx;

    // Input word.
    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [BYTE_W-1:0]       aux_byte;
        logic [SEL_W-1:0]        button_sel;
        logic signed [POS_W-1:0] new_x;
        logic signed [POS_W-1:0] new_y;
    } t_in_item;

    // Result word.
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [BTN_N-1:0]        button_state;
        logic [POS_W-1:0]        event_count;
        logic signed [POS_W-1:0] event_x;
        logic signed [POS_W-1:0] event_y;
        logic signed [POS_W-1:0] motion_x;
        logic signed [POS_W-1:0] motion_y;
        logic                    packet_done;
    } t_out_item;

    // Configuration write word.
    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } t_cfg_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic move;
        logic commit;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_dp_stat;

endpackage

// File: hdl/pmt_stream_if.sv
// ============================================================================
// Valid/ready stream interface
// One channel carrying a word of any packed type under a valid/ready handshake.
// ============================================================================
interface pmt_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/pmt_div.sv
// ============================================================================
// Signed restoring divider
// Divides a signed dividend by a positive divisor one quotient bit per cycle,
// truncating toward zero; the remainder takes the sign of the dividend.
// ============================================================================
module pmt_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [pmt_pkg::REM_W-1:0]    i_dividend,
    input  logic [pmt_pkg::DIVS_W-1:0]          i_divisor,
    output logic                                o_done,
    output logic signed [pmt_pkg::QUOT_W-1:0]   o_quot,
    output logic signed [pmt_pkg::DIVS_W:0]     o_rem
);
    localparam int STEPS = pmt_pkg::REM_W;
    localparam int CNT_W = $clog2(STEPS);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [pmt_pkg::REM_W-1:0]     r_q;
    logic [pmt_pkg::DIVS_W-1:0]    r_r;
    logic [pmt_pkg::DIVS_W-1:0]    r_d;
    logic                          r_neg;

    logic [pmt_pkg::DIVS_W:0]      shifted;
    logic [pmt_pkg::DIVS_W:0]      diff;
    logic                          fits;
    logic [pmt_pkg::REM_W-1:0]     magnitude;

    // Magnitude of the dividend at start.
    assign magnitude = i_dividend[pmt_pkg::REM_W-1] ? (~i_dividend + 1'b1) : i_dividend;

    // One trial subtraction per step.
    assign shifted = {r_r, r_q[pmt_pkg::REM_W-1]};
    assign diff    = shifted - {1'b0, r_d};
    assign fits    = (shifted >= {1'b0, r_d});

    // Step sequencing; the partial remainder and quotient carry no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= magnitude;
            r_r   <= '0;
            r_d   <= i_divisor;
            r_neg <= i_dividend[pmt_pkg::REM_W-1];
        end else if (r_busy) begin
            r_q <= {r_q[pmt_pkg::REM_W-2:0], fits};
            r_r <= fits ? diff[pmt_pkg::DIVS_W-1:0] : shifted[pmt_pkg::DIVS_W-1:0];
        end
    end

    // Signs restored for truncation toward zero.
    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign o_rem  = r_neg ? -$signed({1'b0, r_r}) : $signed({1'b0, r_r});

endmodule

// File: hdl/pmt_dpath.sv
// ============================================================================
// PS/2 mouse tracker datapath
// Holds configuration, packet assembly, position, remainders, counters and
// button records, and the result register. Two dividers scale the motion.
// ============================================================================
module pmt_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pmt_pkg::t_ctrl_cmd    i_cmd,
    output pmt_pkg::t_dp_stat     o_stat,
    input  pmt_pkg::t_in_item     i_in_data,
    input  logic                  i_cfg_valid,
    input  pmt_pkg::t_cfg_word    i_cfg_data,
    output pmt_pkg::t_out_item    o_out_data
);
    typedef struct packed {
        logic signed [pmt_pkg::POS_W-1:0] y;
        logic signed [pmt_pkg::POS_W-1:0] x;
    } t_pos;

    // Clamp to a window: below min takes min, then above max takes max.
    function automatic logic signed [pmt_pkg::POS_W-1:0] clamp_pos(
        input logic signed [pmt_pkg::QUOT_W-1:0] v,
        input logic signed [pmt_pkg::POS_W-1:0]  lo,
        input logic signed [pmt_pkg::POS_W-1:0]  hi
    );
        logic signed [pmt_pkg::QUOT_W-1:0] t;
        logic signed [pmt_pkg::QUOT_W-1:0] lo_w;
        logic signed [pmt_pkg::QUOT_W-1:0] hi_w;
        lo_w = $signed({{(pmt_pkg::QUOT_W-pmt_pkg::POS_W){lo[pmt_pkg::POS_W-1]}}, lo});
        hi_w = $signed({{(pmt_pkg::QUOT_W-pmt_pkg::POS_W){hi[pmt_pkg::POS_W-1]}}, hi});
        t = v;
        if (t < lo_w) t = lo_w;
        if (t > hi_w) t = hi_w;
        return t[pmt_pkg::POS_W-1:0];
    endfunction

    // Configuration registers.
    logic signed [pmt_pkg::POS_W-1:0]  r_min_x, r_max_x, r_min_y, r_max_y;
    logic [pmt_pkg::DIVS_W-1:0]        r_div_x, r_div_y;
    logic                              r_track;

    // Tracker state.
    logic signed [pmt_pkg::POS_W-1:0]  r_cur_x, r_cur_y, n_cur_x, n_cur_y;
    logic signed [pmt_pkg::REM_W-1:0]  r_rem_x, r_rem_y, n_rem_x, n_rem_y;
    logic [pmt_pkg::POS_W-1:0]         r_acc_x, r_acc_y, n_acc_x, n_acc_y;
    logic [pmt_pkg::BTN_N-1:0]         r_held, n_held;
    logic [pmt_pkg::POS_W-1:0]         r_press_count [pmt_pkg::BTN_N];
    logic [pmt_pkg::POS_W-1:0]         n_press_count [pmt_pkg::BTN_N];
    logic [pmt_pkg::POS_W-1:0]         r_rel_cnt [pmt_pkg::BTN_N];
    logic [pmt_pkg::POS_W-1:0]         n_rel_cnt [pmt_pkg::BTN_N];
    t_pos                              r_press_pos [pmt_pkg::BTN_N];
    t_pos                              n_press_pos [pmt_pkg::BTN_N];
    t_pos                              r_rel_pos [pmt_pkg::BTN_N];
    t_pos                              n_rel_pos [pmt_pkg::BTN_N];
    logic [1:0]                        r_byte_idx, n_byte_idx;

    // Working registers without reset.
    logic [pmt_pkg::BYTE_W-1:0]        r_pkt [2];
    logic [pmt_pkg::BYTE_W-1:0]        n_pkt [2];
    pmt_pkg::t_in_item                 r_item;
    logic signed [8:0]                 r_dx;
    logic signed [9:0]                 r_dy;
    logic signed [pmt_pkg::POS_W-1:0]  r_mv_x, r_mv_y;
    pmt_pkg::t_out_item                r_out, n_out;

    // Packet decode.
    logic [pmt_pkg::BYTE_W-1:0]        flags;
    logic                              ovf;
    logic signed [8:0]                 dx;
    logic signed [9:0]                 dy;
    logic signed [pmt_pkg::REM_W-1:0]  dvd_x, dvd_y;
    logic [pmt_pkg::DIVS_W-1:0]        dvs_x, dvs_y;
    logic                              done_x, done_y;
    logic signed [pmt_pkg::QUOT_W-1:0] quot_x, quot_y;
    logic signed [pmt_pkg::DIVS_W:0]   rem_x, rem_y;
    logic signed [pmt_pkg::QUOT_W-1:0] sum_x, sum_y;
    logic [pmt_pkg::SEL_W-1:0]         sel;
    logic                              drop;
    t_pos                              ev_pos;

    assign flags = r_pkt[0];
    assign ovf   = flags[pmt_pkg::FLAG_XOVF] | flags[pmt_pkg::FLAG_YOVF];
    assign dx    = ovf ? '0 : $signed({flags[pmt_pkg::FLAG_XSIGN], r_pkt[1]});
    // Y is inverted so that positive motion points down the screen.
    assign dy    = ovf ? '0 :
                   -$signed({flags[pmt_pkg::FLAG_YSIGN], flags[pmt_pkg::FLAG_YSIGN],
                             r_item.aux_byte});

    // Scaled motion added to the carried remainder.
    assign dvd_x = r_rem_x + $signed({{5{dx[8]}}, dx, 3'b000});
    assign dvd_y = r_rem_y + $signed({{4{dy[9]}}, dy, 3'b000});
    assign dvs_x = (r_div_x == '0) ? pmt_pkg::DEF_DIV_X : r_div_x;
    assign dvs_y = (r_div_y == '0) ? pmt_pkg::DEF_DIV_Y : r_div_y;

    pmt_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd_x),
        .i_divisor  (dvs_x),
        .o_done     (done_x),
        .o_quot     (quot_x),
        .o_rem      (rem_x)
    );

    pmt_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd_y),
        .i_divisor  (dvs_y),
        .o_done     (done_y),
        .o_quot     (quot_y),
        .o_rem      (rem_y)
    );

    // Status for the controller.
    assign o_stat.need_div = (pmt_pkg::t_req'(r_item.req_type) == pmt_pkg::REQ_AUX_BYTE)
                             && (r_byte_idx[1] == 1'b1) && r_track;
    assign o_stat.div_done = done_x & done_y;

    // Candidate position after the move.
    assign sum_x = $signed({{2{r_cur_x[pmt_pkg::POS_W-1]}}, r_cur_x}) + quot_x;
    assign sum_y = $signed({{2{r_cur_y[pmt_pkg::POS_W-1]}}, r_cur_y}) + quot_y;

    assign sel  = (r_item.button_sel == 2'd3) ? 2'd2 : r_item.button_sel;
    assign drop = (r_byte_idx == 2'd0) &&
                  ((r_item.aux_byte == pmt_pkg::MOUSE_ACK) ||
                   (r_item.aux_byte == pmt_pkg::MOUSE_RESEND) ||
                   (r_item.aux_byte == pmt_pkg::MOUSE_SELF_TEST) ||
                   !r_item.aux_byte[pmt_pkg::FLAG_SYNC]);

    // Next state of the item being committed.
    always_comb begin
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_rem_x       = r_rem_x;
        n_rem_y       = r_rem_y;
        n_acc_x       = r_acc_x;
        n_acc_y       = r_acc_y;
        n_held        = r_held;
        n_press_count = r_press_count;
        n_rel_cnt     = r_rel_cnt;
        n_press_pos   = r_press_pos;
        n_rel_pos     = r_rel_pos;
        n_byte_idx    = r_byte_idx;
        n_pkt         = r_pkt;
        n_out         = r_out;
        ev_pos        = '0;
        if (i_cmd.commit) begin
            n_out = '0;
            case (pmt_pkg::t_req'(r_item.req_type))
                pmt_pkg::REQ_AUX_BYTE: begin
                    if (drop) begin
                        n_byte_idx = r_byte_idx;
                    end else if (r_byte_idx[1] == 1'b0) begin
                        n_pkt[r_byte_idx[0]] = r_item.aux_byte;
                        n_byte_idx = r_byte_idx + 2'd1;
                    end else begin
                        n_byte_idx        = 2'd0;
                        n_out.packet_done = 1'b1;
                        if (r_track) begin
                            n_acc_x = r_acc_x + {{7{r_dx[8]}}, r_dx};
                            n_acc_y = r_acc_y + {{6{r_dy[9]}}, r_dy};
                            n_rem_x = $signed({rem_x[pmt_pkg::DIVS_W], rem_x});
                            n_rem_y = $signed({rem_y[pmt_pkg::DIVS_W], rem_y});
                            n_cur_x = r_mv_x;
                            n_cur_y = r_mv_y;
                            n_held  = flags[pmt_pkg::BTN_N-1:0];
                            // Edge on each button, stamped with the new position.
                            for (int b = 0; b < pmt_pkg::BTN_N; b++) begin
                                if (flags[b] && !r_held[b]) begin
                                    n_press_count[b] = r_press_count[b] + 1'b1;
                                    n_press_pos[b]   = {r_mv_y, r_mv_x};
                                end else if (!flags[b] && r_held[b]) begin
                                    n_rel_cnt[b] = r_rel_cnt[b] + 1'b1;
                                    n_rel_pos[b] = {r_mv_y, r_mv_x};
                                end
                            end
                        end
                    end
                end
                pmt_pkg::REQ_SET_POS: begin
                    n_cur_x = clamp_pos($signed({{2{r_item.new_x[pmt_pkg::POS_W-1]}},
                                                 r_item.new_x}), r_min_x, r_max_x);
                    n_cur_y = clamp_pos($signed({{2{r_item.new_y[pmt_pkg::POS_W-1]}},
                                                 r_item.new_y}), r_min_y, r_max_y);
                end
                pmt_pkg::REQ_READ_PRESS: begin
                    n_out.event_count  = r_press_count[sel];
                    ev_pos             = r_press_pos[sel];
                    n_press_count[sel] = '0;
                end
                pmt_pkg::REQ_READ_RELEASE: begin
                    n_out.event_count = r_rel_cnt[sel];
                    ev_pos            = r_rel_pos[sel];
                    n_rel_cnt[sel]    = '0;
                end
                pmt_pkg::REQ_READ_MOTION: begin
                    n_out.motion_x = $signed(r_acc_x);
                    n_out.motion_y = $signed(r_acc_y);
                    n_acc_x        = '0;
                    n_acc_y        = '0;
                end
                default: begin
                    n_byte_idx = r_byte_idx;
                end
            endcase
            n_out.pos_x        = n_cur_x;
            n_out.pos_y        = n_cur_y;
            n_out.button_state = n_held;
            n_out.event_x      = ev_pos.x;
            n_out.event_y      = ev_pos.y;
        end
    end

    // Configuration and tracker state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x    <= pmt_pkg::RST_MIN_X;
            r_max_x    <= pmt_pkg::RST_MAX_X;
            r_min_y    <= pmt_pkg::RST_MIN_Y;
            r_max_y    <= pmt_pkg::RST_MAX_Y;
            r_div_x    <= pmt_pkg::DEF_DIV_X;
            r_div_y    <= pmt_pkg::DEF_DIV_Y;
            r_track    <= 1'b1;
            r_cur_x    <= pmt_pkg::RST_CUR_X;
            r_cur_y    <= pmt_pkg::RST_CUR_Y;
            r_rem_x    <= '0;
            r_rem_y    <= '0;
            r_acc_x    <= '0;
            r_acc_y    <= '0;
            r_held     <= '0;
            r_byte_idx <= '0;
            for (int b = 0; b < pmt_pkg::BTN_N; b++) begin
                r_press_count[b] <= '0;
                r_rel_cnt[b]     <= '0;
                r_press_pos[b]   <= '0;
                r_rel_pos[b]     <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (pmt_pkg::t_cfg_idx'(i_cfg_data.index))
                    pmt_pkg::CFG_MIN_X:    r_min_x <= $signed(i_cfg_data.value);
                    pmt_pkg::CFG_MAX_X:    r_max_x <= $signed(i_cfg_data.value);
                    pmt_pkg::CFG_MIN_Y:    r_min_y <= $signed(i_cfg_data.value);
                    pmt_pkg::CFG_MAX_Y:    r_max_y <= $signed(i_cfg_data.value);
                    pmt_pkg::CFG_DIV_X:    r_div_x <= i_cfg_data.value[pmt_pkg::DIVS_W-1:0];
                    pmt_pkg::CFG_DIV_Y:    r_div_y <= i_cfg_data.value[pmt_pkg::DIVS_W-1:0];
                    pmt_pkg::CFG_TRACK_EN: r_track <= i_cfg_data.value[0];
                    default:               r_track <= r_track;
                endcase
            end
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_rem_x       <= n_rem_x;
            r_rem_y       <= n_rem_y;
            r_acc_x       <= n_acc_x;
            r_acc_y       <= n_acc_y;
            r_held        <= n_held;
            r_byte_idx    <= n_byte_idx;
            r_press_count <= n_press_count;
            r_rel_cnt     <= n_rel_cnt;
            r_press_pos   <= n_press_pos;
            r_rel_pos     <= n_rel_pos;
        end
    end

    // Captured item, packet bytes, motion and the result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.div_start) begin
            r_dx <= dx;
            r_dy <= dy;
        end
        if (i_cmd.move) begin
            if ((quot_x != '0) || (quot_y != '0)) begin
                r_mv_x <= clamp_pos(sum_x, r_min_x, r_max_x);
                r_mv_y <= clamp_pos(sum_y, r_min_y, r_max_y);
            end else begin
                r_mv_x <= r_cur_x;
                r_mv_y <= r_cur_y;
            end
        end
        r_pkt <= n_pkt;
        r_out <= n_out;
    end

    assign o_out_data = r_out;

endmodule

// File: hdl/pmt_ctrl.sv
// ============================================================================
// PS/2 mouse tracker controller
// Sequences each word through decode and commit, with division and move for a
// tracked packet's last byte, and owns the input and result handshakes.
// ============================================================================
module pmt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output pmt_pkg::t_ctrl_cmd o_cmd,
    input  pmt_pkg::t_dp_stat  i_stat
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_MOVE,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    // The result register can take a new word when empty or being drained.
    assign slot_free = !r_out_valid || i_out_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state    = S_COMMIT;
            end
            S_COMMIT: begin
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.commit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    // State and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // A result appears only as the commit step of a word.
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_COMMIT))
        else $error("result valid rose without a commit");

    // An accepted word goes straight to decode.
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted word did not enter decode");

    // Division finishing moves the word on to the position update.
    a_div_to_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_stat.div_done) |=> (r_state == S_MOVE))
        else $error("division finished but no move followed");

    // A commit never overwrites a result that is still held.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_state != S_IDLE || r_out_valid))
        else $error("held result was lost");

endmodule

// File: hdl/ps2_mouse_position_tracker.sv
// ============================================================================
// PS/2 mouse position tracker
// Assembles mouse packets into motion, position and button records, and
// serves position, button and motion requests.
// ============================================================================
// An accepted input word goes through decode and commit, and its result is
// registered as the controller returns to idle, when the input is ready again.
// A byte that completes a packet while tracking is enabled also goes through
// division and move: the scaled X and Y motion goes through two restoring
// dividers that run side by side and retire one quotient bit per cycle over
// 17 steps, started from decode and seen to finish in the division state, and
// the new position is clamped in the move state. A result still waiting on
// the output holds the next word at its commit step, so the input stays not
// ready until that result is taken. Configuration writes are taken at any
// time and should be made while the block is idle.
module ps2_mouse_position_tracker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pmt_stream_if.sink    i_in,
    pmt_stream_if.source  o_out,
    pmt_stream_if.sink    i_cfg
);
    pmt_pkg::t_ctrl_cmd cmd;
    pmt_pkg::t_dp_stat  stat;
    logic               in_ready;
    logic               out_valid;

    pmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    pmt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_out_data  (o_out.data)
    );

    // Handshakes; configuration words are always taken.
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign i_cfg.ready = 1'b1;

endmodule

// File: verif/pmt_position_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// PS/2 mouse position tracker checker
// Watches the input, result and register channels of the tracker and keeps
// its own copy of the tracker state. For every accepted input word it works
// out the result word, and it compares each accepted result word field by
// field with the oldest one still waiting.
// ============================================================================
module pmt_position_checker
    import pmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  t_cfg_word i_cfg_data,
    output int        o_fail_count,
    output int        o_pending
);

    // Window and scaling registers.
    int               win_min_x, win_max_x, win_min_y, win_max_y;
    logic [DIVS_W-1:0] div_x_reg, div_y_reg;
    logic             track_en;

    // Tracker state.
    int               cur_x, cur_y;
    int               rem_x, rem_y;
    logic [15:0]      acc_x, acc_y;
    logic [2:0]       held;
    logic [15:0]      press_count [BTN_N];
    logic [31:0]      press_at  [BTN_N];
    logic [15:0]      release_cnt [BTN_N];
    logic [31:0]      release_at  [BTN_N];
    logic [7:0]       pkt_bytes [2];
    int               pkt_index;

    t_out_item        expected_reports [$];
    int               fail_count = 0;
    int               pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic int clamp_to(int v, int lo, int hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    task automatic reset_tracker();
        win_min_x = 0;
        win_max_x = VIRT_W - 1;
        win_min_y = 0;
        win_max_y = VIRT_H - 1;
        div_x_reg = DIVS_W'(8);
        div_y_reg = DIVS_W'(16);
        track_en  = 1'b1;
        cur_x     = VIRT_W / 2;
        cur_y     = VIRT_H / 2;
        rem_x     = 0;
        rem_y     = 0;
        acc_x     = '0;
        acc_y     = '0;
        held      = '0;
        for (int b = 0; b < BTN_N; b++) begin
            press_count[b] = '0;
            press_at[b]    = '0;
            release_cnt[b] = '0;
            release_at[b]  = '0;
        end
        pkt_bytes[0] = '0;
        pkt_bytes[1] = '0;
        pkt_index    = 0;
    endtask

    task automatic write_register(input t_cfg_word w);
        case (t_cfg_idx'(w.index))
            CFG_MIN_X:    win_min_x = int'($signed(w.value));
            CFG_MAX_X:    win_max_x = int'($signed(w.value));
            CFG_MIN_Y:    win_min_y = int'($signed(w.value));
            CFG_MAX_Y:    win_max_y = int'($signed(w.value));
            CFG_DIV_X:    div_x_reg = w.value[DIVS_W-1:0];
            CFG_DIV_Y:    div_y_reg = w.value[DIVS_W-1:0];
            CFG_TRACK_EN: track_en  = w.value[0];
            default: ;
        endcase
    endtask

    // Apply one packet's motion (Y already pointing down) and button levels.
    task automatic move_and_buttons(input int dx, input int dy, input logic [2:0] nb);
        int divx;
        int divy;
        int px;
        int py;
        divx = (div_x_reg != 0) ? int'(div_x_reg) : 8;
        divy = (div_y_reg != 0) ? int'(div_y_reg) : 16;
        acc_x = acc_x + dx[15:0];
        acc_y = acc_y + dy[15:0];

        // Scaled motion goes through the remainders; division truncates toward zero.
        rem_x = rem_x + dx * 8;
        rem_y = rem_y + dy * 8;
        px = rem_x / divx;
        py = rem_y / divy;
        rem_x = rem_x - px * divx;
        rem_y = rem_y - py * divy;
        if (px != 0 || py != 0) begin
            cur_x = clamp_to(cur_x + px, win_min_x, win_max_x);
            cur_y = clamp_to(cur_y + py, win_min_y, win_max_y);
        end

        // Button edges record the count and the position after the move.
        for (int b = 0; b < BTN_N; b++) begin
            if (nb[b] && !held[b]) begin
                press_count[b] = press_count[b] + 16'd1;
                press_at[b]    = {cur_y[15:0], cur_x[15:0]};
            end else if (!nb[b] && held[b]) begin
                release_cnt[b] = release_cnt[b] + 16'd1;
                release_at[b]  = {cur_y[15:0], cur_x[15:0]};
            end
        end
        held = nb;
    endtask

    // Work out the result word of one input word and update the state.
    task automatic track_word(input t_in_item w, output t_out_item r);
        logic [1:0] sel;
        logic [7:0] f;
        int         dx;
        int         dy;
        r = '0;
        sel = (w.button_sel == 2'd3) ? 2'd2 : w.button_sel;
        case (t_req'(w.req_type))
            REQ_AUX_BYTE: begin
                if (pkt_index == 0 && (w.aux_byte == MOUSE_ACK || w.aux_byte == MOUSE_RESEND ||
                    w.aux_byte == MOUSE_SELF_TEST || !w.aux_byte[FLAG_SYNC])) begin
                    // Not a packet start: dropped.
                end else if (pkt_index < 2) begin
                    pkt_bytes[pkt_index] = w.aux_byte;
                    pkt_index++;
                end else begin
                    f  = pkt_bytes[0];
                    dx = int'(pkt_bytes[1]) - (f[FLAG_XSIGN] ? 256 : 0);
                    dy = int'(w.aux_byte) - (f[FLAG_YSIGN] ? 256 : 0);
                    pkt_index = 0;
                    r.packet_done = 1'b1;
                    if (f[FLAG_XOVF] || f[FLAG_YOVF]) begin
                        dx = 0;
                        dy = 0;
                    end
                    if (track_en)
                        move_and_buttons(dx, -dy, f[2:0]);
                end
            end
            REQ_SET_POS: begin
                cur_x = clamp_to(int'(w.new_x), win_min_x, win_max_x);
                cur_y = clamp_to(int'(w.new_y), win_min_y, win_max_y);
            end
            REQ_READ_PRESS: begin
                r.event_count = press_count[sel];
                {r.event_y, r.event_x} = press_at[sel];
                press_count[sel] = '0;
            end
            REQ_READ_RELEASE: begin
                r.event_count = release_cnt[sel];
                {r.event_y, r.event_x} = release_at[sel];
                release_cnt[sel] = '0;
            end
            REQ_READ_MOTION: begin
                r.motion_x = acc_x;
                r.motion_y = acc_y;
                acc_x = '0;
                acc_y = '0;
            end
            default: ;
        endcase
        r.pos_x        = cur_x[15:0];
        r.pos_y        = cur_y[15:0];
        r.button_state = held;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s expected 0x%04h, got 0x%04h", $time, name, want, got);
        end
    endtask

    // Compare first, then take register writes, then predict the new word.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item made;
        if (!i_rst_n) begin
            reset_tracker();
            expected_reports.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    fail_count++;
                    $display("%0t: result word expected none, got 0x%h",
                             $time, i_out_data);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("pos_x", want.pos_x, i_out_data.pos_x);
                    check_field("pos_y", want.pos_y, i_out_data.pos_y);
                    check_field("button_state", 16'(want.button_state),
                                16'(i_out_data.button_state));
                    check_field("event_count", want.event_count, i_out_data.event_count);
                    check_field("event_x", want.event_x, i_out_data.event_x);
                    check_field("event_y", want.event_y, i_out_data.event_y);
                    check_field("motion_x", want.motion_x, i_out_data.motion_x);
                    check_field("motion_y", want.motion_y, i_out_data.motion_y);
                    check_field("packet_done", 16'(want.packet_done),
                                16'(i_out_data.packet_done));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                write_register(i_cfg_data);
            if (i_in_valid && i_in_ready) begin
                track_word(i_in_data, made);
                expected_reports.push_back(made);
            end
        end
        pending_count = expected_reports.size();
    end

endmodule

// File: verif/tb_ps2_mouse_position_tracker.sv
`timescale 1ns / 1ps
// ============================================================================
// PS/2 mouse position tracker testbench
// Drives mouse bytes and requests into the tracker through several window
// and scaling settings, with random gaps on both sides, and lets the checker
// compare every result word with its own prediction.
// ============================================================================
module tb_ps2_mouse_position_tracker;
    import pmt_pkg::*;

    localparam int WORDS_PER_PHASE = 200;
    localparam int PHASES          = 7;
    localparam int SETTLE_CYCLES   = 40;
    localparam int TIMEOUT_NS      = 5_000_000;

    // One setting of all seven registers.
    typedef struct packed {
        logic [15:0]       min_x;
        logic [15:0]       max_x;
        logic [15:0]       min_y;
        logic [15:0]       max_y;
        logic [DIVS_W-1:0] div_x;
        logic [DIVS_W-1:0] div_y;
        logic              track;
    } t_window_plan;

    logic i_clk;
    logic i_rst_n;
    int   in_idle_pct;
    int   out_idle_pct;
    int   fail_total;
    int   reports_waiting;

    pmt_stream_if #(.t_payload(t_in_item))  in_if ();
    pmt_stream_if #(.t_payload(t_out_item)) out_if ();
    pmt_stream_if #(.t_payload(t_cfg_word)) cfg_if ();

    ps2_mouse_position_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    pmt_position_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_if.valid),
        .i_in_ready   (in_if.ready),
        .i_in_data    (in_if.data),
        .i_out_valid  (out_if.valid),
        .i_out_ready  (out_if.ready),
        .i_out_data   (out_if.data),
        .i_cfg_valid  (cfg_if.valid),
        .i_cfg_ready  (cfg_if.ready),
        .i_cfg_data   (cfg_if.data),
        .o_fail_count (fail_total),
        .o_pending    (reports_waiting)
    );

    // Clock, 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // The result side stalls at random.
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("ps2_mouse_position_tracker: mismatch");
        $finish;
    end

    // A word with every field random and the given request.
    function automatic t_in_item make_word(t_req req);
        logic [63:0] bits;
        t_in_item    w;
        bits = {$urandom, $urandom};
        w = bits[$bits(t_in_item)-1:0];
        w.req_type = req;
        return w;
    endfunction

    // Offer one word after a random gap and wait until it is taken.
    task automatic send_word(input t_in_item w);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic send_aux(input logic [7:0] b);
        t_in_item w;
        w = make_word(REQ_AUX_BYTE);
        w.aux_byte = b;
        send_word(w);
    endtask

    task automatic send_packet(input logic [7:0] f, input logic [7:0] x,
                               input logic [7:0] y);
        send_aux(f);
        send_aux(x);
        send_aux(y);
    endtask

    task automatic send_pos(input logic [15:0] x, input logic [15:0] y);
        t_in_item w;
        w = make_word(REQ_SET_POS);
        w.new_x = x;
        w.new_y = y;
        send_word(w);
    endtask

    task automatic send_read(input t_req req, input logic [1:0] sel);
        t_in_item w;
        w = make_word(req);
        w.button_sel = sel;
        send_word(w);
    endtask

    // Stop offering words until every result word has come back.
    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (reports_waiting != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        @(negedge i_clk);
        cfg_if.valid      <= 1'b1;
        cfg_if.data.index <= idx;
        cfg_if.data.value <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    function automatic t_window_plan pick_plan(int p);
        t_window_plan pl;
        int           lo_x;
        int           lo_y;
        lo_x = int'($urandom_range(2000)) - 1000;
        lo_y = int'($urandom_range(2000)) - 1000;
        pl.min_x = 16'(lo_x);
        pl.max_x = 16'(lo_x + int'($urandom_range(1500)));
        pl.min_y = 16'(lo_y);
        pl.max_y = 16'(lo_y + int'($urandom_range(1500)));
        pl.div_x = DIVS_W'($urandom_range(1, 64));
        pl.div_y = DIVS_W'($urandom_range(1, 64));
        pl.track = 1'b1;
        case (p)
            0: pl = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 15'd1, 15'd1, 1'b1};
            1: pl = {16'd0, 16'd639, 16'd0, 16'd199, 15'd8, 15'd16, 1'b1};
            2: pl = {-16'sd100, 16'sd100, -16'sd50, 16'sd50, 15'd32767, 15'd32767, 1'b1};
            3: pl.track = 1'b0;
            // Minimum above maximum: every move or set lands on the maximum.
            4: pl = {16'sd10, -16'sd10, 16'sd5, -16'sd5, 15'd3, 15'd5, 1'b1};
            // A window of a single point.
            5: pl = {16'sd5, 16'sd5, -16'sd7, -16'sd7, 15'd1, 15'd32767, 1'b1};
            default: ;
        endcase
        return pl;
    endfunction

    task automatic program_phase(input int p);
        t_window_plan pl;
        pl = pick_plan(p);
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(CFG_MIN_X, pl.min_x);
        write_reg(CFG_MAX_X, pl.max_x);
        write_reg(CFG_MIN_Y, pl.min_y);
        write_reg(CFG_MAX_Y, pl.max_y);
        write_reg(CFG_DIV_X, 16'(pl.div_x));
        write_reg(CFG_DIV_Y, 16'(pl.div_y));
        write_reg(CFG_TRACK_EN, 16'(pl.track));
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Edge values, every request and each filter and overflow case.
    task automatic run_directed();
        send_read(REQ_READ_MOTION, 2'd0);
        send_read(REQ_READ_PRESS, 2'd0);
        send_pos(16'h7FFF, 16'h8000);
        send_pos(16'h8000, 16'h7FFF);
        send_pos(16'd320, 16'd100);
        // Bytes that never start a packet.
        send_aux(MOUSE_ACK);
        send_aux(MOUSE_RESEND);
        send_aux(MOUSE_SELF_TEST);
        send_aux(8'h00);
        send_aux(8'hF7);
        // Largest right move, largest downward move, left button.
        send_packet(8'h29, 8'h7F, 8'h80);
        // Largest left move, both signs set, right and middle buttons.
        send_packet(8'h3E, 8'h80, 8'hFF);
        // Overflow drops motion; reply codes inside a packet are plain data.
        send_packet(8'hCF, MOUSE_ACK, MOUSE_SELF_TEST);
        send_read(REQ_READ_PRESS, 2'd3);
        send_read(REQ_READ_RELEASE, 2'd0);
        send_read(REQ_READ_RELEASE, 2'd1);
        send_read(REQ_READ_MOTION, 2'd0);
        send_read(REQ_READ_PRESS, 2'd1);
        send_packet(8'h08, 8'h00, 8'h00);
    endtask

    // Mostly whole packets with random content, mixed with requests,
    // stray bytes at packet start and lone bytes that break the framing.
    task automatic run_random(input int target);
        int         counted;
        int         pick;
        logic [7:0] f;
        logic [7:0] b;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(99);
            if ($urandom_range(49) == 0)
                drain();
            if (pick < 60) begin
                f = 8'($urandom);
                f[FLAG_SYNC] = 1'b1;
                if ($urandom_range(7) != 0) begin
                    f[FLAG_XOVF] = 1'b0;
                    f[FLAG_YOVF] = 1'b0;
                end
                send_packet(f, 8'($urandom), 8'($urandom));
                counted += 3;
            end else if (pick < 70) begin
                case ($urandom_range(3))
                    0: b = MOUSE_ACK;
                    1: b = MOUSE_RESEND;
                    2: b = MOUSE_SELF_TEST;
                    default: begin
                        b = 8'($urandom);
                        b[FLAG_SYNC] = 1'b0;
                    end
                endcase
                send_aux(b);
            end else if (pick < 75) begin
                send_aux(8'($urandom));
                counted++;
            end else if (pick < 83) begin
                send_pos(16'($urandom), 16'($urandom));
                counted++;
            end else if (pick < 90) begin
                send_read(REQ_READ_PRESS, 2'($urandom));
                counted++;
            end else if (pick < 96) begin
                send_read(REQ_READ_RELEASE, 2'($urandom));
                counted++;
            end else begin
                send_read(REQ_READ_MOTION, 2'($urandom));
                counted++;
            end
        end
    endtask

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        out_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        in_idle_pct  = 29;
        out_idle_pct = 75;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            // Receiver slow first, then sender slow, then neither idles.
            if (p == 2) begin
                in_idle_pct  = 75;
                out_idle_pct = 29;
            end else if (p == 4) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            program_phase(p);
            run_random(WORDS_PER_PHASE);
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_total == 0)
            $display("ps2_mouse_position_tracker: match");
        else
            $display("ps2_mouse_position_tracker: mismatch");
        $finish;
    end

endmodule
